// ----- rtl/mtpw_pkg.sv -----
package mtpw_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_W         = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_DESIRED_LENGTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TENSION_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH_FLOOR   = 3'd4;

  localparam logic [CFG_W-1:0] PROP_GAIN_RST     = 31'd65536;
  localparam logic [CFG_W-1:0] TENSION_LIMIT_RST = 31'd65536;

  typedef struct packed {
    logic signed [31:0] rel_pos_x;
    logic signed [31:0] rel_pos_y;
    logic signed [31:0] rel_pos_z;
    logic signed [31:0] rel_vel_x;
    logic signed [31:0] rel_vel_y;
    logic signed [31:0] rel_vel_z;
    logic               tether_end;
    logic               round_end;
    logic [30:0]        measured_tension;
    logic [30:0]        measured_min_length;
  } item_t;

  typedef struct packed {
    logic [CFG_W-1:0] desired_length;
    logic [CFG_W-1:0] prop_gain;
    logic [CFG_W-1:0] deriv_gain;
    logic [CFG_W-1:0] tension_limit;
    logic [CFG_W-1:0] length_floor;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_SQRT,
    ST_DIV,
    ST_ACC,
    ST_GATE,
    ST_PD,
    ST_RATE,
    ST_UPD
  } back_state_t;

endpackage

// ----- rtl/mtpw_front.sv -----
module mtpw_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  mtpw_pkg::item_t      in_item,
  output logic                 item_valid,
  output mtpw_pkg::item_t      item,
  input  logic                 item_pop
);
  import mtpw_pkg::*;

  item_t       mem_r [2];
  logic [1:0]  count_r;
  logic        wr_r;
  logic        rd_r;
  logic        push;
  logic        pop;

  assign in_stall   = (count_r == 2'd2);
  assign push       = in_valid && !in_stall;
  assign item_valid = (count_r != 2'd0);
  assign pop        = item_pop && item_valid;
  assign item       = mem_r[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
      wr_r    <= 1'b0;
      rd_r    <= 1'b0;
    end else begin
      if (push) begin
        wr_r <= !wr_r;
      end
      if (pop) begin
        rd_r <= !rd_r;
      end
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ----- rtl/mtpw_back.sv -----
module mtpw_back #(
  parameter int FRAC_BITS = mtpw_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               item_valid,
  input  mtpw_pkg::item_t    item,
  output logic               item_pop,
  input  mtpw_pkg::cfg_t     cfg,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] spool_rate,
  output logic               any_gated
);
  import mtpw_pkg::*;

  localparam longint START_FULL = longint'(1000) << FRAC_BITS;
  localparam logic signed [31:0] START_RATE =
    (START_FULL > 64'sh7FFFFFFF) ? 32'sh7FFFFFFF : 32'(START_FULL);

  back_state_t st_r, st_nxt;

  item_t               it_r;
  logic [2:0]          cnt_r;
  logic signed [63:0]  prod_r;
  logic [63:0]         sq_r, pos_r, neg_r;
  logic [63:0]         n_r, res_r, bit_r;
  logic [32:0]         len_r;
  logic [33:0]         rem_r;
  logic [63:0]         dvd_r, quo_r;
  logic [5:0]          step_r;
  logic                qneg_r;
  logic [39:0]         len_sum_r;
  logic signed [39:0]  vel_sum_r;
  logic signed [31:0]  min_r;
  logic                gated_r;
  logic signed [40:0]  err_r;
  logic signed [52:0]  pprod_r;
  logic signed [75:0]  pdacc_r;
  logic signed [31:0]  rate_r;
  logic                out_valid_r;
  logic signed [31:0]  out_rate_r;
  logic                out_gated_r;

  logic signed [31:0]  mul_a, mul_b;
  logic [1:0]          sel;
  logic [63:0]         sq_try;
  logic [34:0]         div_try;
  logic [40:0]         len_add;
  logic signed [41:0]  proj;
  logic signed [42:0]  vel_add;
  logic signed [40:0]  err_c;
  logic                active;
  logic signed [40:0]  vel_ext;
  logic signed [20:0]  pd_op;
  logic signed [31:0]  pd_gain;
  logic signed [52:0]  pd_prod;
  logic signed [75:0]  pd_term;
  logic signed [75:0]  shr;
  logic                out_free;
  logic [2:0]          acc_k;

  assign out_valid  = out_valid_r;
  assign spool_rate = out_rate_r;
  assign any_gated  = out_gated_r;
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    sel = cnt_r[1:0];
    if (cnt_r > 3'd2) begin
      sel = 2'(cnt_r - 3'd3);
    end
    case (sel)
      2'd0:    mul_a = it_r.rel_pos_x;
      2'd1:    mul_a = it_r.rel_pos_y;
      default: mul_a = it_r.rel_pos_z;
    endcase
    if (cnt_r < 3'd3) begin
      mul_b = mul_a;
    end else begin
      case (sel)
        2'd0:    mul_b = it_r.rel_vel_x;
        2'd1:    mul_b = it_r.rel_vel_y;
        default: mul_b = it_r.rel_vel_z;
      endcase
    end
  end

  assign acc_k   = cnt_r - 3'd1;
  assign sq_try  = res_r + bit_r;
  assign div_try = {rem_r, dvd_r[63]} - {2'b00, len_r};
  assign len_add = {1'b0, len_sum_r} + {8'd0, len_r};
  assign proj    = qneg_r ? -$signed({1'b0, quo_r[40:0]}) : $signed({1'b0, quo_r[40:0]});
  assign vel_add = {{3{vel_sum_r[39]}}, vel_sum_r} + {proj[41], proj};
  assign err_c   = $signed({1'b0, len_sum_r}) - $signed({10'd0, cfg.desired_length});
  assign active  = !err_c[40] && (err_c != 41'sd0)
                   && (it_r.measured_tension < cfg.tension_limit)
                   && (it_r.measured_min_length > cfg.length_floor);
  assign vel_ext = {vel_sum_r[39], vel_sum_r};

  always_comb begin
    case (cnt_r[1:0])
      2'd0:    pd_op = $signed({1'b0, err_r[19:0]});
      2'd1:    pd_op = err_r[40:20];
      2'd2:    pd_op = $signed({1'b0, vel_ext[19:0]});
      default: pd_op = vel_ext[40:20];
    endcase
    pd_gain = (cnt_r[1:0] < 2'd2) ? $signed({1'b0, cfg.prop_gain})
                                  : $signed({1'b0, cfg.deriv_gain});
    pd_prod = pd_gain * pd_op;
    if (acc_k[0]) begin
      pd_term = $signed({{23{pprod_r[52]}}, pprod_r}) <<< 20;
    end else begin
      pd_term = $signed({{23{pprod_r[52]}}, pprod_r});
    end
    shr = pdacc_r >>> FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    item_pop = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          st_nxt   = ST_MUL;
        end
      end
      ST_MUL:  if (cnt_r == 3'd6) st_nxt = ST_SQRT;
      ST_SQRT: begin
        if (bit_r[0]) begin
          st_nxt = ((res_r >> 1) == 64'd0 && !(n_r >= sq_try)) ? ST_ACC : ST_DIV;
        end
      end
      ST_DIV:  if (step_r == 6'd63) st_nxt = ST_ACC;
      ST_ACC:  st_nxt = it_r.tether_end ? ST_GATE : ST_IDLE;
      ST_GATE: st_nxt = active ? ST_PD : ST_UPD;
      ST_PD:   if (cnt_r == 3'd4) st_nxt = ST_RATE;
      ST_RATE: st_nxt = ST_UPD;
      ST_UPD: begin
        if (!it_r.round_end || out_free) begin
          st_nxt = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      ST_IDLE: begin
        it_r  <= item;
        cnt_r <= 3'd0;
        sq_r  <= 64'd0;
        pos_r <= 64'd0;
        neg_r <= 64'd0;
      end
      ST_MUL: begin
        prod_r <= mul_a * mul_b;
        cnt_r  <= cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          if (acc_k < 3'd3) begin
            sq_r <= sq_r + prod_r;
          end else if (prod_r[63]) begin
            neg_r <= neg_r - prod_r;
          end else begin
            pos_r <= pos_r + prod_r;
          end
        end
        if (cnt_r == 3'd6) begin
          n_r   <= sq_r;
          res_r <= 64'd0;
          bit_r <= 64'd1 << 62;
        end
      end
      ST_SQRT: begin
        if (n_r >= sq_try) begin
          n_r   <= n_r - sq_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          if (n_r >= sq_try) begin
            len_r <= 33'((res_r >> 1) + bit_r);
          end else begin
            len_r <= 33'(res_r >> 1);
          end
          rem_r  <= 34'd0;
          step_r <= 6'd0;
          quo_r  <= 64'd0;
          qneg_r <= (neg_r > pos_r);
          dvd_r  <= (pos_r >= neg_r) ? (pos_r - neg_r) : (neg_r - pos_r);
        end
      end
      ST_DIV: begin
        step_r <= step_r + 6'd1;
        dvd_r  <= dvd_r << 1;
        if (!div_try[34]) begin
          rem_r <= div_try[33:0];
          quo_r <= {quo_r[62:0], 1'b1};
        end else begin
          rem_r <= {rem_r[32:0], dvd_r[63]};
          quo_r <= {quo_r[62:0], 1'b0};
        end
      end
      ST_GATE: begin
        err_r   <= err_c;
        cnt_r   <= 3'd0;
        pdacc_r <= 76'sd0;
        rate_r  <= 32'sd0;
      end
      ST_PD: begin
        pprod_r <= pd_prod;
        cnt_r   <= cnt_r + 3'd1;
        if (cnt_r != 3'd0) begin
          pdacc_r <= pdacc_r + pd_term;
        end
      end
      ST_RATE: begin
        if (shr[75] && !(&shr[75:31])) begin
          rate_r <= 32'sh80000000;
        end else if (!shr[75] && (|shr[75:31])) begin
          rate_r <= 32'sh7FFFFFFF;
        end else begin
          rate_r <= shr[31:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_sum_r   <= 40'd0;
      vel_sum_r   <= 40'sd0;
      min_r       <= START_RATE;
      gated_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (st_r == ST_ACC) begin
        len_sum_r <= len_add[40] ? 40'hFF_FFFF_FFFF : len_add[39:0];
        if (vel_add > 43'sh7F_FFFF_FFFF) begin
          vel_sum_r <= 40'sh7F_FFFF_FFFF;
        end else if (vel_add < -43'sh80_0000_0000) begin
          vel_sum_r <= 40'sh80_0000_0000;
        end else begin
          vel_sum_r <= vel_add[39:0];
        end
      end
      if (st_r == ST_UPD && (!it_r.round_end || out_free)) begin
        len_sum_r <= 40'd0;
        vel_sum_r <= 40'sd0;
        if (it_r.round_end) begin
          out_valid_r <= 1'b1;
          out_rate_r  <= (rate_r < min_r) ? rate_r : min_r;
          out_gated_r <= gated_r;
          min_r       <= START_RATE;
          gated_r     <= 1'b0;
        end else if (rate_r < min_r) begin
          min_r <= rate_r;
        end
      end
      if (st_r == ST_GATE && !active) begin
        gated_r <= 1'b1;
      end
    end
  end

endmodule

// ----- rtl/multi_tether_pd_winch_rate_top.sv -----
// Channel  Handshake           Payload
// in       in_valid/in_stall   rel_pos_*, rel_vel_*, tether_end, round_end, measured_*
// out      out_valid/out_stall spool_rate, any_gated
// cfg      cfg_valid/cfg_ready cfg_index, cfg_wdata
//
// Each segment steps through taking the request, the multiply pass, the square root,
// the bit-serial divide and the accumulate; a zero-length segment skips the divide.
// A tether end adds the gate, PD, rate and update steps (gate and update when gated).
// A two-entry queue takes the next requests while the back end works.
// Synchronous active-low reset; configuration is always ready.
// A held result stalls the back end only at a round end.
module multi_tether_pd_winch_rate_top #(
  parameter int FRAC_BITS = mtpw_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            in_rel_pos_x,
  input  logic signed [31:0]            in_rel_pos_y,
  input  logic signed [31:0]            in_rel_pos_z,
  input  logic signed [31:0]            in_rel_vel_x,
  input  logic signed [31:0]            in_rel_vel_y,
  input  logic signed [31:0]            in_rel_vel_z,
  input  logic                          in_tether_end,
  input  logic                          in_round_end,
  input  logic [30:0]                   in_measured_tension,
  input  logic [30:0]                   in_measured_min_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_spool_rate,
  output logic                          out_any_gated,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mtpw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mtpw_pkg::CFG_W-1:0]    cfg_wdata
);
  import mtpw_pkg::*;

  cfg_t  cfg_r;
  item_t in_item;
  item_t item;
  logic  item_valid;
  logic  item_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.desired_length <= '0;
      cfg_r.prop_gain      <= PROP_GAIN_RST;
      cfg_r.deriv_gain     <= '0;
      cfg_r.tension_limit  <= TENSION_LIMIT_RST;
      cfg_r.length_floor   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_DESIRED_LENGTH: cfg_r.desired_length <= cfg_wdata;
        CFG_PROP_GAIN:      cfg_r.prop_gain      <= cfg_wdata;
        CFG_DERIV_GAIN:     cfg_r.deriv_gain     <= cfg_wdata;
        CFG_TENSION_LIMIT:  cfg_r.tension_limit  <= cfg_wdata;
        CFG_LENGTH_FLOOR:   cfg_r.length_floor   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    in_item.rel_pos_x           = in_rel_pos_x;
    in_item.rel_pos_y           = in_rel_pos_y;
    in_item.rel_pos_z           = in_rel_pos_z;
    in_item.rel_vel_x           = in_rel_vel_x;
    in_item.rel_vel_y           = in_rel_vel_y;
    in_item.rel_vel_z           = in_rel_vel_z;
    in_item.tether_end          = in_tether_end;
    in_item.round_end           = in_round_end;
    in_item.measured_tension    = in_measured_tension;
    in_item.measured_min_length = in_measured_min_length;
  end

  mtpw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop)
  );

  mtpw_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .cfg        (cfg_r),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .spool_rate (out_spool_rate),
    .any_gated  (out_any_gated)
  );

endmodule

// ----- sim/multi_tether_pd_winch_rate_top_test.sv -----
`timescale 1ns / 1ps

module multi_tether_pd_winch_rate_top_test;
  import mtpw_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int WATCHDOG_LIMIT = 6000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct {
    logic signed [31:0] rate;
    logic gated;
  } round_result_t;

  class winch_rate_scoreboard;
    logic [30:0] desired_length, prop_gain, deriv_gain, tension_limit, length_floor;
    longint length_sum, velocity_sum, min_rate;
    bit gated_seen;
    round_result_t expected_rates[$];
    int errors;

    function void reset_state();
      desired_length = 0;
      prop_gain = PROP_GAIN_RST;
      deriv_gain = 0;
      tension_limit = TENSION_LIMIT_RST;
      length_floor = 0;
      length_sum = 0;
      velocity_sum = 0;
      min_rate = start_rate();
      gated_seen = 0;
      errors = 0;
    endfunction

    function longint start_rate();
      longint s;
      s = longint'(1000) << FRAC;
      return (s > 64'sd2147483647) ? 64'sd2147483647 : s;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
      case (idx)
        CFG_DESIRED_LENGTH: desired_length = val;
        CFG_PROP_GAIN: prop_gain = val;
        CFG_DERIV_GAIN: deriv_gain = val;
        CFG_TENSION_LIMIT: tension_limit = val;
        CFG_LENGTH_FLOOR: length_floor = val;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= res + b) begin
          n = n - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b = b >> 2;
      end
      return res;
    endfunction

    function longint pd_rate(longint err, longint vel);
      logic signed [127:0] s, r;
      logic signed [127:0] pg, dg, e, v;
      pg = {97'd0, prop_gain};
      dg = {97'd0, deriv_gain};
      e = err;
      v = vel;
      s = pg * e + dg * v;
      r = s >>> FRAC;
      if (r > 128'sd2147483647) return 64'sd2147483647;
      if (r < -128'sd2147483648) return -64'sd2147483648;
      return longint'(r);
    endfunction

    function void note_request(item_t it);
      longint p[3], v[3], t, proj, err, rate;
      longint unsigned sq, len, pos, neg, mag, q;
      p[0] = it.rel_pos_x; p[1] = it.rel_pos_y; p[2] = it.rel_pos_z;
      v[0] = it.rel_vel_x; v[1] = it.rel_vel_y; v[2] = it.rel_vel_z;
      sq = 0; pos = 0; neg = 0; proj = 0;
      for (int i = 0; i < 3; i++) sq += longint'(p[i] * p[i]);
      len = int_sqrt(sq);
      if (len != 0) begin
        for (int i = 0; i < 3; i++) begin
          t = p[i] * v[i];
          if (t >= 0) pos += t;
          else neg += -t;
        end
        mag = (pos >= neg) ? pos - neg : neg - pos;
        q = mag / len;
        proj = (pos >= neg) ? longint'(q) : -longint'(q);
      end
      length_sum += longint'(len);
      if (length_sum > 64'sd1099511627775) length_sum = 64'sd1099511627775;
      velocity_sum += proj;
      if (velocity_sum > 64'sd549755813887) velocity_sum = 64'sd549755813887;
      if (velocity_sum < -64'sd549755813888) velocity_sum = -64'sd549755813888;
      if (!it.tether_end) return;
      err = length_sum - longint'(desired_length);
      if (err > 0 && it.measured_tension < tension_limit &&
          it.measured_min_length > length_floor) begin
        rate = pd_rate(err, velocity_sum);
      end else begin
        rate = 0;
        gated_seen = 1;
      end
      if (rate < min_rate) min_rate = rate;
      length_sum = 0;
      velocity_sum = 0;
      if (!it.round_end) return;
      expected_rates.push_back('{rate: min_rate[31:0], gated: gated_seen});
      min_rate = start_rate();
      gated_seen = 0;
    endfunction

    task report(string what);
      $display("tb: mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    task check_result(logic signed [31:0] rate, logic gated);
      round_result_t e;
      if (expected_rates.size() == 0) begin
        report($sformatf("unexpected result rate=%0d gated=%0b", rate, gated));
        return;
      end
      e = expected_rates.pop_front();
      if (rate !== e.rate)
        report($sformatf("spool_rate got %0d want %0d", rate, e.rate));
      if (gated !== e.gated)
        report($sformatf("any_gated got %0b want %0b", gated, e.gated));
    endtask
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall;
  logic signed [31:0] in_rel_pos_x, in_rel_pos_y, in_rel_pos_z;
  logic signed [31:0] in_rel_vel_x, in_rel_vel_y, in_rel_vel_z;
  logic in_tether_end, in_round_end;
  logic [30:0] in_measured_tension, in_measured_min_length;
  logic out_valid, out_stall;
  logic signed [31:0] out_spool_rate;
  logic out_any_gated;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  winch_rate_scoreboard sb;
  bit busy_mode;
  int idle_count = 0;

  multi_tether_pd_winch_rate_top DUT (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  function int rand_gap();
    int r;
    if (busy_mode) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 0;
    end else if (busy_mode) begin
      out_stall <= 0;
    end else begin
      int r;
      r = $urandom_range(0, 99);
      if (out_stall) out_stall <= (r < 85);
      else out_stall <= (r < 20);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall)
        sb.note_request('{in_rel_pos_x, in_rel_pos_y, in_rel_pos_z, in_rel_vel_x,
                          in_rel_vel_y, in_rel_vel_z, in_tether_end, in_round_end,
                          in_measured_tension, in_measured_min_length});
      if (out_valid && !out_stall) sb.check_result(out_spool_rate, out_any_gated);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_count <= 0;
      else idle_count <= idle_count + 1;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task send_segment(item_t it);
    int gap;
    gap = rand_gap();
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_rel_pos_x <= it.rel_pos_x;
    in_rel_pos_y <= it.rel_pos_y;
    in_rel_pos_z <= it.rel_pos_z;
    in_rel_vel_x <= it.rel_vel_x;
    in_rel_vel_y <= it.rel_vel_y;
    in_rel_vel_z <= it.rel_vel_z;
    in_tether_end <= it.tether_end;
    in_round_end <= it.round_end;
    in_measured_tension <= it.measured_tension;
    in_measured_min_length <= it.measured_min_length;
    do @(posedge clk); while (in_stall);
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.expected_rates.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_reg(logic [CFG_IDX_W-1:0] idx, logic [30:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, val);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task write_all(logic [30:0] dl, pg, dg, tl, lf);
    write_reg(CFG_DESIRED_LENGTH, dl);
    write_reg(CFG_PROP_GAIN, pg);
    write_reg(CFG_DERIV_GAIN, dg);
    write_reg(CFG_TENSION_LIMIT, tl);
    write_reg(CFG_LENGTH_FLOOR, lf);
  endtask

  function logic signed [31:0] rand_coord(int cls);
    case (cls)
      0: return 0;
      1: return $signed($urandom_range(0, 32'h1FFFFF)) - 32'sd1048576;
      2: return $signed($urandom_range(0, 32'h3FFFFFF)) - 32'sd33554432;
      default: return $urandom;
    endcase
  endfunction

  function item_t rand_segment(bit relaxed);
    item_t it;
    int pc, vc, r;
    r = $urandom_range(0, 99);
    pc = (r < 4) ? 0 : (r < 40) ? 1 : (r < 75) ? 2 : 3;
    vc = $urandom_range(0, 3);
    it.rel_pos_x = rand_coord(pc);
    it.rel_pos_y = rand_coord(pc);
    it.rel_pos_z = rand_coord(pc);
    it.rel_vel_x = rand_coord(vc);
    it.rel_vel_y = rand_coord(vc);
    it.rel_vel_z = rand_coord(vc);
    it.tether_end = ($urandom_range(0, 2) == 0);
    it.round_end = ($urandom_range(0, 2) == 0);
    if (relaxed && $urandom_range(0, 9) < 8) begin
      it.measured_tension = 31'($urandom_range(0, 1000));
      it.measured_min_length = 31'h7FFF0000 + 31'($urandom_range(0, 16'hFFFF));
    end else begin
      it.measured_tension = 31'($urandom);
      it.measured_min_length = 31'($urandom);
    end
    return it;
  endfunction

  task random_phase(int n, bit relaxed);
    item_t it;
    repeat (n) begin
      if ($urandom_range(0, 99) < 3) busy_mode = ~busy_mode;
      send_segment(rand_segment(relaxed));
    end
    busy_mode = 0;
    it = rand_segment(relaxed);
    it.tether_end = 1;
    it.round_end = 1;
    send_segment(it);
    drain();
  endtask

  task directed_phase();
    item_t it;
    it = '{32'sd65536, 0, 0, 32'sd65536, 0, 0, 1'b1, 1'b1, 31'd0, 31'd1};
    send_segment(it);
    it = '{0, 0, 0, 32'sd100, 32'sd100, 32'sd100, 1'b1, 1'b1, 31'd0, 31'd1};
    send_segment(it);
    it = '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
           32'h7FFFFFFF, 1'b0, 1'b1, 31'd0, 31'h7FFFFFFF};
    send_segment(it);
    send_segment(it);
    it.tether_end = 1;
    it.round_end = 0;
    send_segment(it);
    it = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
           32'h7FFFFFFF, 1'b1, 1'b1, 31'd0, 31'h7FFFFFFF};
    send_segment(it);
    it = '{32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
           32'h80000000, 1'b1, 1'b1, 31'h7FFFFFFF, 31'h7FFFFFFF};
    send_segment(it);
    it = '{32'sd300000, -32'sd400000, 32'sd5, -32'sd70000, 32'sd90000, 32'sd1,
           1'b1, 1'b0, 31'd65536, 31'd5};
    send_segment(it);
    it.measured_tension = 31'd65535;
    it.measured_min_length = 31'd0;
    send_segment(it);
    it.measured_min_length = 31'd1;
    it.round_end = 1;
    send_segment(it);
    it = '{-32'sd1, -32'sd1, -32'sd1, -32'sd1, 32'sd1, -32'sd1, 1'b1, 1'b1,
           31'd0, 31'd1};
    send_segment(it);
    drain();
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    busy_mode = 0;
    rst_n = 0;
    in_valid = 0;
    in_rel_pos_x = 0; in_rel_pos_y = 0; in_rel_pos_z = 0;
    in_rel_vel_x = 0; in_rel_vel_y = 0; in_rel_vel_z = 0;
    in_tether_end = 0; in_round_end = 0;
    in_measured_tension = 0; in_measured_min_length = 0;
    cfg_valid = 0; cfg_index = 0; cfg_wdata = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    repeat (SETTLE_CYCLES) @(posedge clk);

    directed_phase();
    random_phase(200, 1);
    write_all(31'd0, 31'd0, 31'd0, 31'd0, 31'd0);
    random_phase(120, 1);
    write_all(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF);
    random_phase(120, 1);
    write_all(31'd0, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'd0);
    random_phase(180, 1);
    write_all(31'($urandom_range(0, 32'h3FFFF)), 31'($urandom_range(0, 32'h3FFFF)),
              31'($urandom_range(0, 32'h3FFFF)), 31'h7FFFFFFF,
              31'($urandom_range(0, 100)));
    random_phase(180, 1);
    write_all(31'($urandom), 31'($urandom), 31'($urandom), 31'($urandom),
              31'($urandom));
    random_phase(150, 0);
    write_all(31'($urandom_range(0, 32'hFFFFF)), 31'd65536, 31'd32768,
              31'($urandom_range(32'h100000, 32'h7FFFFFFF)),
              31'($urandom_range(0, 32'hFFFF)));
    random_phase(180, 1);

    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
